/* src/page_bitmap_allocator_defines.svh */
// Assertion macros shared by the page bitmap allocator RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pba_pkg.sv */
// Package for the page bitmap allocator: sizes, op and status codes, shared types.
// No dependencies.
`timescale 1ns / 1ps

package pba_pkg;

  localparam int unsigned PAGE_COUNT = 1048576;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam int unsigned PAGE_W     = 20;
  localparam int unsigned BIT_W      = 6;
  localparam int unsigned WORD_W     = PAGE_W - BIT_W;
  localparam int unsigned GROUP_W    = WORD_W - BIT_W;
  localparam int unsigned CHUNK_W    = GROUP_W - 5;
  localparam int unsigned MAP_WORDS  = 1 << WORD_W;
  localparam int unsigned GROUPS     = 1 << GROUP_W;
  localparam int unsigned LINE_W     = 64;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned RESERVED_W = 21;

  localparam logic [RESERVED_W-1:0] RESERVED_RESET = 21'h500;

  typedef enum logic [1:0] {
    OP_REGION = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_MEM      = 2'd1;
  localparam logic [1:0] STATUS_DOUBLE_FREE = 2'd2;

  // Clamped page range of one region add; valid only when ok is set.
  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] first_page;
    logic [PAGE_W-1:0] last_page;
  } region_t;

  // Lowest set bit: {found, index}.
  function automatic logic [BIT_W:0] ffs64(input logic [LINE_W-1:0] v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = LINE_W - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, BIT_W'(i)};
    end
    return r;
  endfunction

endpackage

/* src/pba_ifs.sv */
// Valid/ready channel interfaces for the page bitmap allocator.
// Depends on pba_pkg.
`timescale 1ns / 1ps

interface pba_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [pba_pkg::ADDR_W-1:0]   region_base;
  logic [pba_pkg::ADDR_W-1:0]   region_length;
  logic                         region_usable;
  logic [pba_pkg::PAGE_W-1:0]   page;

  modport source (output valid, op, region_base, region_length, region_usable, page,
                  input ready);
  modport sink   (input valid, op, region_base, region_length, region_usable, page,
                  output ready);
endinterface

interface pba_out_if;
  logic                         valid;
  logic                         ready;
  logic [pba_pkg::PAGE_W-1:0]   page_res;
  logic [1:0]                   status;

  modport source (output valid, page_res, status, input ready);
  modport sink   (input valid, page_res, status, output ready);
endinterface

/* src/pba_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pba_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/pba_region_prep.sv */
// Four-stage pipeline turning a byte region into a clamped page range.
// Depends on pba_pkg.
`timescale 1ns / 1ps

module pba_region_prep (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [pba_pkg::ADDR_W-1:0]       base,
  input  logic [pba_pkg::ADDR_W-1:0]       length,
  input  logic [pba_pkg::RESERVED_W-1:0]   bnd,
  output logic                             done,
  output pba_pkg::region_t                 region
);
  import pba_pkg::*;

  localparam int unsigned AW = ADDR_W + 1;   // rounded base keeps its carry
  localparam int unsigned EW = ADDR_W + 2;   // end page can pass 2^(AW-SHIFT)
  localparam logic [AW-1:0] ALIGN_MASK = AW'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [EW-1:0] PAGE_LIMIT = EW'(PAGE_COUNT);

  logic              v1_r, v2_r, v3_r, done_r;
  logic [AW-1:0]     aligned_r;
  logic [ADDR_W-1:0] base_r, len_r, rem_r;
  logic [AW-1:0]     start_r;
  logic [EW-1:0]     end_r, lo_r;
  logic [RESERVED_W-1:0] bnd_r;
  region_t           region_r;

  logic [AW-1:0]     adj;
  logic [EW-1:0]     lo_nxt, hi, hi_m1;

  assign adj    = aligned_r - {1'b0, base_r};
  assign lo_nxt = ({1'b0, start_r} > EW'(bnd_r)) ? {1'b0, start_r} : EW'(bnd_r);
  assign hi     = (end_r < PAGE_LIMIT) ? end_r : PAGE_LIMIT;
  assign hi_m1  = hi - EW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
    // stage 1: round base up to a page
    if (start) begin
      aligned_r <= ({1'b0, base} + ALIGN_MASK) & ~ALIGN_MASK;
      base_r    <= base;
      len_r     <= length;
      bnd_r     <= bnd;
    end
    // stage 2: whole pages left after rounding
    if (v1_r) begin
      rem_r   <= (len_r > adj[ADDR_W-1:0]) ? len_r - adj[ADDR_W-1:0] : '0;
      start_r <= aligned_r >> PAGE_SHIFT;
    end
    // stage 3: end page and lower clamp
    if (v2_r) begin
      end_r <= {1'b0, start_r} + EW'(rem_r >> PAGE_SHIFT);
      lo_r  <= lo_nxt;
    end
    // stage 4: upper clamp and emptiness check
    if (v3_r) begin
      region_r.ok         <= lo_r < hi;
      region_r.first_page <= lo_r[PAGE_W-1:0];
      region_r.last_page  <= hi_m1[PAGE_W-1:0];
    end
  end

  assign done   = done_r;
  assign region = region_r;

endmodule

/* src/page_bitmap_allocator.sv */
// Top level of the page bitmap allocator: sequencer, summary vector, both RAMs.
// Depends on pba_pkg, pba_ifs, pba_ram, pba_region_prep and the defines header.
`timescale 1ns / 1ps
`include "page_bitmap_allocator_defines.svh"

//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+--------------------------------------------
//  in_ch    | in  | valid/ready         | op, region_base, region_length,
//           |     |                     | region_usable, page
//  out_ch   | out | valid/ready         | page_res, status
//  cfg      | in  | cfg_we, no wait     | cfg_wdata = reserved_pages
//
// One transaction at a time; the result waits in an output register, so the next
// transaction is taken meanwhile. No-op, ignored region and allocate with the boundary
// at the page count skip to the result; a free in range reads, then sets the page bit.
// Else allocate runs up to 8 steps of the 32-group top scan, a summary and a bitmap
// read, and at most two retries past a word and a group below the boundary. Region add:
// prep, read and write per 64-page word. Reset clears 16384 bitmap words, input held off.

module page_bitmap_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  pba_in_if.sink                         in_ch,
  pba_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [pba_pkg::RESERVED_W-1:0] cfg_wdata
);
  import pba_pkg::*;

  // Three levels of occupancy:
  //   bitmap RAM  16384 x 64 : one bit per page, 1 = available
  //   summary RAM   256 x 64 : one bit per bitmap word, 1 = word not zero
  //   top_r         256 flops: one bit per summary word, 1 = word not zero
  // Each read-modify-write reads its entry in an earlier state than it writes it, and
  // no RAM is read and written in the same state; no forwarding is needed.

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_TOP,
    ST_ALLOC_SUM,
    ST_ALLOC_WORD,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_REGION_PREP,
    ST_REGION_RD,
    ST_REGION_WR,
    ST_FIN
  } state_t;

  state_t                state_r;
  logic [WORD_W-1:0]     clr_r;
  logic [GROUPS-1:0]     top_r;
  logic [RESERVED_W-1:0] reserved_r;

  // search state
  logic [PAGE_W-1:0]     cur_r;     // lowest page the search may still return
  logic [CHUNK_W-1:0]    chunk_r;   // 32-group slice of top_r under scan
  logic [GROUP_W-1:0]    grp_r;
  logic [WORD_W-1:0]     w_r;       // bitmap word: alloc hit or region sweep
  logic [LINE_W-1:0]     sum_r;

  // captured transaction and its result
  logic [PAGE_W-1:0]     page_in_r;
  logic [PAGE_W-1:0]     res_page_r;
  logic [1:0]            res_status_r;
  logic                  out_valid_r;
  logic [PAGE_W-1:0]     out_page_r;
  logic [1:0]            out_status_r;
  logic                  out_load;

  // RAM ports
  logic                  bm_we, bm_re, sm_we, sm_re;
  logic [WORD_W-1:0]     bm_waddr, bm_raddr;
  logic [GROUP_W-1:0]    sm_waddr, sm_raddr;
  logic [LINE_W-1:0]     bm_wdata, bm_rdata, sm_wdata, sm_rdata;

  // region prep
  logic                  prep_start, prep_done;
  region_t               region;

  // boundary, clamped to the page count
  logic [RESERVED_W-1:0] bnd;
  assign bnd = (reserved_r > RESERVED_W'(PAGE_COUNT)) ? RESERVED_W'(PAGE_COUNT) : reserved_r;

  logic in_acc;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign prep_start   = in_acc && (op_t'(in_ch.op) == OP_REGION) && in_ch.region_usable;

  // result moves to the output register once it is empty or being drained
  assign out_load     = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) reserved_r <= RESERVED_RESET;
    else if (cfg_we) reserved_r <= cfg_wdata;
  end

  // ---------------------------------------------------------------- search logic
  logic [GROUP_W-1:0] cur_grp;
  logic [31:0]        top_bits;
  logic [4:0]         top_cut;
  logic [BIT_W:0]     top_hit, sum_hit, word_hit;
  logic [GROUP_W-1:0] top_grp, grp_nx;
  logic [BIT_W-1:0]   sum_cut, word_cut;
  logic [WORD_W-1:0]  sum_word, w_nx;
  logic [PAGE_W-1:0]  alloc_page;
  logic               alloc_take;
  logic [LINE_W-1:0]  new_word, new_sum;
  logic               free_in_range;
  logic [LINE_W-1:0]  reg_mask;

  assign cur_grp    = cur_r[PAGE_W-1 -: GROUP_W];
  assign top_bits   = top_r[{chunk_r, 5'd0} +: 32];
  assign top_cut    = (chunk_r == cur_grp[GROUP_W-1 -: CHUNK_W]) ? cur_grp[4:0] : '0;
  assign top_hit    = ffs64({32'd0, top_bits & (32'hFFFF_FFFF << top_cut)});
  assign top_grp    = {chunk_r, top_hit[4:0]};

  assign sum_cut    = (grp_r == cur_grp) ? cur_r[2*BIT_W-1:BIT_W] : '0;
  assign sum_hit    = ffs64(sm_rdata & ({LINE_W{1'b1}} << sum_cut));
  assign sum_word   = {grp_r, sum_hit[BIT_W-1:0]};
  assign grp_nx     = grp_r + GROUP_W'(1);

  assign word_cut   = (w_r == cur_r[PAGE_W-1:BIT_W]) ? cur_r[BIT_W-1:0] : '0;
  assign word_hit   = ffs64(bm_rdata & ({LINE_W{1'b1}} << word_cut));
  assign alloc_page = {w_r, word_hit[BIT_W-1:0]};
  assign alloc_take = word_hit[BIT_W] && (32'(alloc_page) < 32'(PAGE_COUNT));
  assign new_word   = bm_rdata & ~(LINE_W'(1) << word_hit[BIT_W-1:0]);
  assign new_sum    = sum_r & ~(LINE_W'(1) << w_r[BIT_W-1:0]);
  assign w_nx       = w_r + WORD_W'(1);

  assign free_in_range = ({1'b0, page_in_r} >= bnd)
                      && (32'(page_in_r) < 32'(PAGE_COUNT));

  // set bits of the current sweep word that fall inside [first_page, last_page]
  assign reg_mask =
      (({LINE_W{1'b1}}) << ((w_r == region.first_page[PAGE_W-1:BIT_W])
                              ? region.first_page[BIT_W-1:0] : BIT_W'(0)))
    & (({LINE_W{1'b1}}) >> ((w_r == region.last_page[PAGE_W-1:BIT_W])
                              ? ~region.last_page[BIT_W-1:0] : BIT_W'(0)));

  // ---------------------------------------------------------------- RAM control
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = w_r;
    bm_wdata = '0;
    bm_re    = 1'b0;
    bm_raddr = w_r;
    sm_we    = 1'b0;
    sm_waddr = w_r[WORD_W-1 -: GROUP_W];
    sm_wdata = '0;
    sm_re    = 1'b0;
    sm_raddr = w_r[WORD_W-1 -: GROUP_W];
    unique case (state_r)
      ST_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        sm_we    = 1'b1;
        sm_waddr = clr_r[GROUP_W-1:0];
      end
      ST_ALLOC_TOP: begin
        if (top_hit[BIT_W]) begin
          sm_re    = 1'b1;
          sm_raddr = top_grp;
        end
      end
      ST_ALLOC_SUM: begin
        if (sum_hit[BIT_W]) begin
          bm_re    = 1'b1;
          bm_raddr = sum_word;
        end
      end
      ST_ALLOC_WORD: begin
        if (alloc_take) begin
          bm_we    = 1'b1;
          bm_wdata = new_word;
          // word emptied: drop its summary bit
          if (new_word == '0) begin
            sm_we    = 1'b1;
            sm_waddr = grp_r;
            sm_wdata = new_sum;
          end
        end
      end
      ST_FREE_RD: begin
        if (free_in_range) begin
          bm_re    = 1'b1;
          bm_raddr = page_in_r[PAGE_W-1:BIT_W];
          sm_re    = 1'b1;
          sm_raddr = page_in_r[PAGE_W-1 -: GROUP_W];
        end
      end
      ST_FREE_WR: begin
        if (!bm_rdata[page_in_r[BIT_W-1:0]]) begin
          bm_we    = 1'b1;
          bm_waddr = page_in_r[PAGE_W-1:BIT_W];
          bm_wdata = bm_rdata | (LINE_W'(1) << page_in_r[BIT_W-1:0]);
          sm_we    = 1'b1;
          sm_waddr = page_in_r[PAGE_W-1 -: GROUP_W];
          sm_wdata = sm_rdata | (LINE_W'(1) << page_in_r[2*BIT_W-1:BIT_W]);
        end
      end
      ST_REGION_RD: begin
        bm_re = 1'b1;
        sm_re = 1'b1;
      end
      ST_REGION_WR: begin
        bm_we    = 1'b1;
        bm_wdata = bm_rdata | reg_mask;
        sm_we    = 1'b1;
        sm_wdata = sm_rdata | (LINE_W'(1) << w_r[BIT_W-1:0]);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + WORD_W'(1);
          if (clr_r == '1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            page_in_r    <= in_ch.page;
            res_page_r   <= '0;
            res_status_r <= STATUS_OK;
            unique case (op_t'(in_ch.op))
              OP_REGION: state_r <= in_ch.region_usable ? ST_REGION_PREP : ST_FIN;
              OP_ALLOC: begin
                if (32'(bnd) >= 32'(PAGE_COUNT)) begin
                  res_status_r <= STATUS_NO_MEM;
                  state_r      <= ST_FIN;
                end else begin
                  cur_r   <= bnd[PAGE_W-1:0];
                  chunk_r <= bnd[PAGE_W-1 -: CHUNK_W];
                  state_r <= ST_ALLOC_TOP;
                end
              end
              OP_FREE:   state_r <= ST_FREE_RD;
              OP_NOP:    state_r <= ST_FIN;
            endcase
          end
        end
        ST_ALLOC_TOP: begin
          if (top_hit[BIT_W]) begin
            grp_r   <= top_grp;
            state_r <= ST_ALLOC_SUM;
          end else if (chunk_r == '1) begin
            res_status_r <= STATUS_NO_MEM;
            state_r      <= ST_FIN;
          end else begin
            chunk_r <= chunk_r + CHUNK_W'(1);
          end
        end
        ST_ALLOC_SUM: begin
          if (sum_hit[BIT_W]) begin
            sum_r   <= sm_rdata;
            w_r     <= sum_word;
            state_r <= ST_ALLOC_WORD;
          end else if (grp_r == '1) begin
            res_status_r <= STATUS_NO_MEM;
            state_r      <= ST_FIN;
          end else begin
            // group held only words below the cursor: move past it
            cur_r   <= {grp_nx, {(PAGE_W-GROUP_W){1'b0}}};
            chunk_r <= grp_nx[GROUP_W-1 -: CHUNK_W];
            state_r <= ST_ALLOC_TOP;
          end
        end
        ST_ALLOC_WORD: begin
          if (word_hit[BIT_W]) begin
            if (alloc_take) begin
              res_page_r <= alloc_page;
              if (new_word == '0 && new_sum == '0) top_r[grp_r] <= 1'b0;
            end else begin
              res_status_r <= STATUS_NO_MEM;
            end
            state_r <= ST_FIN;
          end else if (w_r == '1) begin
            res_status_r <= STATUS_NO_MEM;
            state_r      <= ST_FIN;
          end else begin
            // word held only pages below the boundary
            cur_r   <= {w_nx, {BIT_W{1'b0}}};
            chunk_r <= w_nx[WORD_W-1 -: CHUNK_W];
            state_r <= ST_ALLOC_TOP;
          end
        end
        ST_FREE_RD: begin
          state_r <= free_in_range ? ST_FREE_WR : ST_FIN;
        end
        ST_FREE_WR: begin
          if (bm_rdata[page_in_r[BIT_W-1:0]]) begin
            res_status_r <= STATUS_DOUBLE_FREE;
          end else begin
            top_r[page_in_r[PAGE_W-1 -: GROUP_W]] <= 1'b1;
          end
          state_r <= ST_FIN;
        end
        ST_REGION_PREP: begin
          if (prep_done) begin
            if (region.ok) begin
              w_r     <= region.first_page[PAGE_W-1:BIT_W];
              state_r <= ST_REGION_RD;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_REGION_RD: begin
          state_r <= ST_REGION_WR;
        end
        ST_REGION_WR: begin
          top_r[w_r[WORD_W-1 -: GROUP_W]] <= 1'b1;
          if (w_r == region.last_page[PAGE_W-1:BIT_W]) begin
            state_r <= ST_FIN;
          end else begin
            w_r     <= w_nx;
            state_r <= ST_REGION_RD;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            out_page_r   <= res_page_r;
            out_status_r <= res_status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.page_res = out_page_r;
  assign out_ch.status   = out_status_r;

  // ---------------------------------------------------------------- instances
  pba_ram #(.DEPTH(MAP_WORDS), .WIDTH(LINE_W)) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  pba_ram #(.DEPTH(GROUPS), .WIDTH(LINE_W)) u_summary_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  pba_region_prep u_region_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (prep_start),
    .base   (in_ch.region_base),
    .length (in_ch.region_length),
    .bnd    (bnd),
    .done   (prep_done),
    .region (region)
  );

  // ---------------------------------------------------------------- assertions
  `PBA_ASSERT_SAME(a_bitmap_rw_split, bm_we, !bm_re, "bitmap RAM read and written together")
  `PBA_ASSERT_SAME(a_summary_rw_split, sm_we, !sm_re, "summary RAM read and written together")
  `PBA_ASSERT_SAME(a_alloc_above_bnd, (state_r == ST_ALLOC_WORD) && alloc_take, ({1'b0, alloc_page} >= bnd), "allocated page below boundary")
  `PBA_ASSERT_NEXT(a_top_follows_summary, sm_we && (sm_wdata != '0), top_r[$past(sm_waddr)], "top bit clear for nonempty summary word")
  `PBA_ASSERT_SAME(a_fail_zero_page, out_valid_r && (out_status_r != STATUS_OK), out_page_r == '0, "failed result carries a page")

endmodule
